// ----- hdl/gble_pkg.sv -----
// Shared types and constants for the gap buffer line editor.
// Used by the editor top level and its port checker; no dependencies.
package gble_pkg;

	localparam int STACK_DEPTH = 256;
	localparam int ADDR_W      = $clog2(STACK_DEPTH);
	localparam int TOP_W       = $clog2(STACK_DEPTH + 1);
	localparam int POS_W       = 9;
	localparam int CHAR_W      = 8;
	localparam int COUNT_W     = 9;
	localparam int CMP_W       = (POS_W > TOP_W) ? POS_W : TOP_W;

	localparam logic [CHAR_W-1:0] CR_CHAR = 8'd13;

	typedef enum logic [2:0] {
		OP_PRELOAD   = 3'd0,
		OP_TYPE      = 3'd1,
		OP_BACKSPACE = 3'd2,
		OP_DELETE    = 3'd3,
		OP_LEFT      = 3'd4,
		OP_RIGHT     = 3'd5,
		OP_LINE      = 3'd6,
		OP_READ      = 3'd7
	} op_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_EMPTY  = 2'd1,
		ST_FULL   = 2'd2,
		ST_BEYOND = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_WALK,
		S_READ,
		S_DONE
	} state_t;

endpackage

// ----- hdl/gap_buffer_line_editor.sv -----
// Gap buffer line editor: two character stacks in synchronous RAMs around a cursor.
// Depends on gble_pkg.
//
// One item at a time. Preload, type, backspace and delete go from the execute state
// straight to the done state. Cursor moves and reads first pass through a walk or read
// state for the RAM read; a refused move or a read beyond the text does not. A line move
// carries up to 256 characters across the cursor, one character per cycle, and a full
// destination stops the walk. From the done state the editor returns to idle before it
// takes the next item. A finished result sits in the output register while the next item
// is accepted. If the receiver still holds that register, the next result waits and the
// input stays closed. No clearing pass after reset.
module gap_buffer_line_editor (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [2:0]                   op,
	input  logic [gble_pkg::CHAR_W-1:0]  ch,
	input  logic [gble_pkg::POS_W-1:0]   position,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [gble_pkg::CHAR_W-1:0]  char_out,
	output logic [gble_pkg::COUNT_W-1:0] left_count,
	output logic [gble_pkg::COUNT_W-1:0] right_count,
	output logic [1:0]                   status
);
	import gble_pkg::*;

	logic [CHAR_W-1:0] left_mem  [STACK_DEPTH];
	logic [CHAR_W-1:0] right_mem [STACK_DEPTH];

	state_t state_q, state_d;
	op_t op_q;
	logic [CHAR_W-1:0] ch_q;
	logic [POS_W-1:0] pos_q;
	logic dir_q;   // 1: source is left stack
	logic line_q;
	logic rsel_q, rsel_d;
	logic [TOP_W-1:0] ltop_q, ltop_d, rtop_q, rtop_d;
	status_t res_status_q, res_status_d;
	logic [CHAR_W-1:0] res_char_q, res_char_d;

	logic out_valid_q;
	logic [CHAR_W-1:0] char_out_q;
	logic [COUNT_W-1:0] left_count_q, right_count_q;
	status_t status_q;
	logic load_out;

	logic lw_en, rw_en, lr_en, rr_en;
	logic [ADDR_W-1:0] lw_addr, rw_addr, lr_addr, rr_addr;
	logic [CHAR_W-1:0] lw_data, rw_data;
	logic [CHAR_W-1:0] left_rd_q, right_rd_q;

	logic [TOP_W-1:0] src_top, dst_top, src_dec, src_dec2;
	logic [CHAR_W-1:0] src_rd;
	logic dst_full;
	logic [CMP_W-1:0] pos_ext, ltop_ext, rtop_ext, diff, raddr;

	assign src_top  = dir_q ? ltop_q : rtop_q;
	assign dst_top  = dir_q ? rtop_q : ltop_q;
	assign src_dec  = src_top - TOP_W'(1);
	assign src_dec2 = src_top - TOP_W'(2);
	assign src_rd   = dir_q ? left_rd_q : right_rd_q;
	assign dst_full = (dst_top == TOP_W'(STACK_DEPTH));

	assign pos_ext  = CMP_W'(pos_q);
	assign ltop_ext = CMP_W'(ltop_q);
	assign rtop_ext = CMP_W'(rtop_q);
	assign diff     = pos_ext - ltop_ext;
	assign raddr    = rtop_ext - CMP_W'(1) - diff;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d      = state_q;
		ltop_d       = ltop_q;
		rtop_d       = rtop_q;
		rsel_d       = rsel_q;
		res_status_d = res_status_q;
		res_char_d   = res_char_q;
		load_out     = 1'b0;
		lw_en        = 1'b0;
		rw_en        = 1'b0;
		lr_en        = 1'b0;
		rr_en        = 1'b0;
		lw_addr      = '0;
		rw_addr      = '0;
		lr_addr      = '0;
		rr_addr      = '0;
		lw_data      = ch_q;
		rw_data      = ch_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid)
					state_d = S_EXEC;
			end
			S_EXEC: begin
				res_char_d   = '0;
				res_status_d = ST_OK;
				state_d      = S_DONE;
				case (op_q)
					OP_PRELOAD: begin
						if (rtop_q == TOP_W'(STACK_DEPTH)) begin
							res_status_d = ST_FULL;
						end else begin
							rw_en   = 1'b1;
							rw_addr = rtop_q[ADDR_W-1:0];
							rtop_d  = rtop_q + TOP_W'(1);
						end
					end
					OP_TYPE: begin
						if (ltop_q == TOP_W'(STACK_DEPTH)) begin
							res_status_d = ST_FULL;
						end else begin
							lw_en   = 1'b1;
							lw_addr = ltop_q[ADDR_W-1:0];
							ltop_d  = ltop_q + TOP_W'(1);
						end
					end
					OP_BACKSPACE: begin
						if (ltop_q == '0)
							res_status_d = ST_EMPTY;
						else
							ltop_d = ltop_q - TOP_W'(1);
					end
					OP_DELETE: begin
						if (rtop_q == '0)
							res_status_d = ST_EMPTY;
						else
							rtop_d = rtop_q - TOP_W'(1);
					end
					OP_LEFT, OP_RIGHT, OP_LINE: begin
						if (src_top == '0) begin
							res_status_d = ST_EMPTY;
						end else if (!line_q && dst_full) begin
							res_status_d = ST_FULL;
						end else begin
							lr_en   = dir_q;
							rr_en   = !dir_q;
							lr_addr = src_dec[ADDR_W-1:0];
							rr_addr = src_dec[ADDR_W-1:0];
							state_d = S_WALK;
						end
					end
					OP_READ: begin
						if (pos_ext < ltop_ext) begin
							lr_en   = 1'b1;
							lr_addr = pos_q[ADDR_W-1:0];
							rsel_d  = 1'b1;
							state_d = S_READ;
						end else if (diff < rtop_ext) begin
							rr_en   = 1'b1;
							rr_addr = raddr[ADDR_W-1:0];
							rsel_d  = 1'b0;
							state_d = S_READ;
						end else begin
							res_status_d = ST_BEYOND;
						end
					end
					default: begin
						res_status_d = ST_OK;
					end
				endcase
			end
			S_WALK: begin
				if (dst_full) begin
					res_status_d = ST_FULL;
					state_d      = S_DONE;
				end else begin
					lw_en   = !dir_q;
					rw_en   = dir_q;
					lw_addr = dst_top[ADDR_W-1:0];
					rw_addr = dst_top[ADDR_W-1:0];
					lw_data = src_rd;
					rw_data = src_rd;
					if (dir_q) begin
						ltop_d = ltop_q - TOP_W'(1);
						rtop_d = rtop_q + TOP_W'(1);
					end else begin
						rtop_d = rtop_q - TOP_W'(1);
						ltop_d = ltop_q + TOP_W'(1);
					end
					if (!line_q || src_rd == CR_CHAR || src_top == TOP_W'(1)) begin
						state_d = S_DONE;
					end else begin
						lr_en   = dir_q;
						rr_en   = !dir_q;
						lr_addr = src_dec2[ADDR_W-1:0];
						rr_addr = src_dec2[ADDR_W-1:0];
					end
				end
			end
			S_READ: begin
				res_char_d = rsel_q ? left_rd_q : right_rd_q;
				state_d    = S_DONE;
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (lw_en)
			left_mem[lw_addr] <= lw_data;
		if (lr_en)
			left_rd_q <= left_mem[lr_addr];
	end

	always_ff @(posedge clk) begin
		if (rw_en)
			right_mem[rw_addr] <= rw_data;
		if (rr_en)
			right_rd_q <= right_mem[rr_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ltop_q      <= '0;
			rtop_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			ltop_q  <= ltop_d;
			rtop_q  <= rtop_d;
			if (load_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			op_q   <= op_t'(op);
			ch_q   <= ch;
			pos_q  <= position;
			dir_q  <= (op_t'(op) == OP_LEFT) || (op_t'(op) == OP_LINE && ch == '0);
			line_q <= (op_t'(op) == OP_LINE);
		end
		rsel_q       <= rsel_d;
		res_status_q <= res_status_d;
		res_char_q   <= res_char_d;
		if (load_out) begin
			char_out_q    <= res_char_q;
			left_count_q  <= COUNT_W'(ltop_q);
			right_count_q <= COUNT_W'(rtop_q);
			status_q      <= res_status_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign char_out    = char_out_q;
	assign left_count  = left_count_q;
	assign right_count = right_count_q;
	assign status      = status_q;

endmodule

// ----- hdl/gble_checker.sv -----
// Port-level checks for the gap buffer line editor, bound to the top level.
// Depends on gble_pkg and gap_buffer_line_editor.
module gble_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic [2:0]                   op,
	input logic [gble_pkg::CHAR_W-1:0]  ch,
	input logic [gble_pkg::POS_W-1:0]   position,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [gble_pkg::CHAR_W-1:0]  char_out,
	input logic [gble_pkg::COUNT_W-1:0] left_count,
	input logic [gble_pkg::COUNT_W-1:0] right_count,
	input logic [1:0]                   status
);
	import gble_pkg::*;

	// one item in flight: ready drops right after an accept
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("item accepted while previous one in flight");

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(op) && $stable(ch)
			&& $stable(position))
		else $error("offered item changed before accept");

	a_beyond_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_BEYOND |-> char_out == '0)
		else $error("read beyond text returned a character");

	a_char_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && char_out != '0 |-> status == ST_OK)
		else $error("character returned with error status");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(char_out) && $stable(status)
			&& $stable(left_count) && $stable(right_count))
		else $error("stalled result changed");

endmodule

bind gap_buffer_line_editor gble_checker u_gble_checker (.*);

// ----- tb/sv/gap_buffer_line_editor_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for gap_buffer_line_editor: a directed table, then random edit traffic.
// Expected: a two-stack text model here, or typed table rows; depends on gble_pkg and the RTL.

module gap_buffer_line_editor_tb;
	import gble_pkg::*;

	localparam int CYCLE_LIMIT  = 2000000;
	localparam int RANDOM_ITEMS = 1700;
	localparam int DRAIN_CYCLES = 300;
	localparam int MAX_REPORTS  = 10;
	localparam int HOLD_AFTER   = 400;
	localparam int HOLD_CYCLES  = 600;

	typedef struct packed {
		logic [CHAR_W-1:0]  chr;
		logic [COUNT_W-1:0] lcnt;
		logic [COUNT_W-1:0] rcnt;
		status_t            st;
	} edit_result_t;

	typedef struct packed {
		op_t               op;
		logic [CHAR_W-1:0] ch;
		logic [POS_W-1:0]  pos;
		bit                typed;
		edit_result_t      res;
	} table_row_t;

	logic                 clk         = 1'b0;
	logic                 arst_n      = 1'b0;
	logic                 in_valid    = 1'b0;
	logic                 in_ready;
	logic [2:0]           op          = OP_PRELOAD;
	logic [CHAR_W-1:0]    ch          = '0;
	logic [POS_W-1:0]     position    = '0;
	logic                 out_valid;
	logic                 out_ready   = 1'b0;
	logic [CHAR_W-1:0]    char_out;
	logic [COUNT_W-1:0]   left_count;
	logic [COUNT_W-1:0]   right_count;
	logic [1:0]           status;

	always #5 clk = ~clk;

	gap_buffer_line_editor dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.op          (op),
		.ch          (ch),
		.position    (position),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.char_out    (char_out),
		.left_count  (left_count),
		.right_count (right_count),
		.status      (status)
	);

	// text model: left of cursor bottom first, right of cursor with the next char on top
	logic [CHAR_W-1:0] text_left  [STACK_DEPTH];
	logic [CHAR_W-1:0] text_right [STACK_DEPTH];
	int left_fill  = 0;
	int right_fill = 0;

	edit_result_t line_results [$];
	table_row_t   directed_rows [$];

	int errors     = 0;
	int accepted   = 0;
	int burst_left = 0;
	int cycles     = 0;
	int rx_mode    = 0;
	int rx_span    = 0;
	int rx_phase   = 0;
	bit hold_rx    = 1'b0;

	function automatic status_t carry_char(input bit from_left);
		status_t st;
		st = ST_OK;
		if (from_left) begin
			if (left_fill == 0) st = ST_EMPTY;
			else if (right_fill >= STACK_DEPTH) st = ST_FULL;
			else begin
				left_fill--;
				text_right[ADDR_W'(right_fill)] = text_left[ADDR_W'(left_fill)];
				right_fill++;
			end
		end else begin
			if (right_fill == 0) st = ST_EMPTY;
			else if (left_fill >= STACK_DEPTH) st = ST_FULL;
			else begin
				right_fill--;
				text_left[ADDR_W'(left_fill)] = text_right[ADDR_W'(right_fill)];
				left_fill++;
			end
		end
		return st;
	endfunction

	function automatic edit_result_t apply_edit(input logic [2:0] o, input logic [CHAR_W-1:0] c,
			input logic [POS_W-1:0] p);
		edit_result_t      r;
		bit                from_left;
		bit                walking;
		logic [CHAR_W-1:0] moved;
		int                idx;
		r.chr = '0;
		r.st  = ST_OK;
		case (o)
		OP_PRELOAD: begin
			if (right_fill >= STACK_DEPTH) r.st = ST_FULL;
			else begin
				text_right[ADDR_W'(right_fill)] = c;
				right_fill++;
			end
		end
		OP_TYPE: begin
			if (left_fill >= STACK_DEPTH) r.st = ST_FULL;
			else begin
				text_left[ADDR_W'(left_fill)] = c;
				left_fill++;
			end
		end
		OP_BACKSPACE: begin
			if (left_fill == 0) r.st = ST_EMPTY;
			else left_fill--;
		end
		OP_DELETE: begin
			if (right_fill == 0) r.st = ST_EMPTY;
			else right_fill--;
		end
		OP_LEFT:  r.st = carry_char(1'b1);
		OP_RIGHT: r.st = carry_char(1'b0);
		OP_LINE: begin
			from_left = (c == 0);
			walking   = ((from_left ? left_fill : right_fill) != 0);
			if (!walking) r.st = ST_EMPTY;
			while (walking) begin
				moved = from_left ? text_left[ADDR_W'(left_fill - 1)]
					: text_right[ADDR_W'(right_fill - 1)];
				if (carry_char(from_left) != ST_OK) begin
					r.st    = ST_FULL;
					walking = 1'b0;
				end else begin
					walking = (moved != CR_CHAR) && ((from_left ? left_fill : right_fill) != 0);
				end
			end
		end
		default: begin
			idx = int'(p);
			if (idx < left_fill) r.chr = text_left[ADDR_W'(idx)];
			else if (idx - left_fill < right_fill)
				r.chr = text_right[ADDR_W'(right_fill - 1 - (idx - left_fill))];
			else r.st = ST_BEYOND;
		end
		endcase
		r.lcnt = left_fill[COUNT_W-1:0];
		r.rcnt = right_fill[COUNT_W-1:0];
		return r;
	endfunction

	task automatic add_row(input op_t o, input logic [CHAR_W-1:0] c, input logic [POS_W-1:0] p,
			input bit typed, input logic [CHAR_W-1:0] xc, input int xl, input int xr,
			input status_t xs);
		table_row_t r;
		r.op       = o;
		r.ch       = c;
		r.pos      = p;
		r.typed    = typed;
		r.res.chr  = xc;
		r.res.lcnt = xl[COUNT_W-1:0];
		r.res.rcnt = xr[COUNT_W-1:0];
		r.res.st   = xs;
		directed_rows.push_back(r);
	endtask

	task automatic drive_item(input logic [2:0] o, input logic [CHAR_W-1:0] c,
			input logic [POS_W-1:0] p, input bit typed, input edit_result_t fixed);
		edit_result_t predicted;
		in_valid <= 1'b1;
		op       <= o;
		ch       <= c;
		position <= p;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predicted = apply_edit(o, c, p);
		line_results.push_back(typed ? fixed : predicted);
		accepted++;
	endtask

	task automatic pace_sender();
		int gap;
		if (burst_left > 0) burst_left--;
		else begin
			gap = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(3) == 0) ? $urandom_range(80, 200) : $urandom_range(0, 30);
		end
	endtask

	task automatic send_edit(input logic [2:0] o, input logic [CHAR_W-1:0] c,
			input logic [POS_W-1:0] p);
		drive_item(o, c, p, 1'b0, '0);
		pace_sender();
	endtask

	task automatic wait_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (line_results.size() != 0);
	endtask

	function automatic logic [CHAR_W-1:0] rnd_char();
		return CHAR_W'($urandom_range(255));
	endfunction

	function automatic logic [POS_W-1:0] rnd_pos();
		return POS_W'($urandom_range(511));
	endfunction

	function automatic logic [CHAR_W-1:0] pick_char(input int cr_odds);
		if (cr_odds > 0 && $urandom_range(cr_odds - 1) == 0) return CR_CHAR;
		return rnd_char();
	endfunction

	function automatic logic [POS_W-1:0] pick_pos();
		int total;
		total = left_fill + right_fill;
		if (total > 0 && $urandom_range(7) != 0) return POS_W'($urandom_range(total - 1));
		return rnd_pos();
	endfunction

	initial begin : stimulus
		int               seg;
		int               kind;
		int               len;
		int               cr_odds;
		int               bias;
		bit               mixed_sides;
		logic [2:0]       side_op;
		logic [2:0]       rnd_op;
		logic [CHAR_W-1:0] line_ch;

		// after reset every pop and move hits an empty stack
		add_row(OP_BACKSPACE, 8'd0,   9'd0,   1'b1, 8'd0,   0, 0, ST_EMPTY);
		add_row(OP_DELETE,    8'd0,   9'd0,   1'b1, 8'd0,   0, 0, ST_EMPTY);
		add_row(OP_LEFT,      8'd0,   9'd0,   1'b1, 8'd0,   0, 0, ST_EMPTY);
		add_row(OP_RIGHT,     8'd0,   9'd0,   1'b1, 8'd0,   0, 0, ST_EMPTY);
		add_row(OP_LINE,      8'd0,   9'd0,   1'b1, 8'd0,   0, 0, ST_EMPTY);
		add_row(OP_LINE,      8'd1,   9'd0,   1'b1, 8'd0,   0, 0, ST_EMPTY);
		add_row(OP_READ,      8'd0,   9'd0,   1'b1, 8'd0,   0, 0, ST_BEYOND);
		add_row(OP_READ,      8'hFF,  9'h1FF, 1'b1, 8'd0,   0, 0, ST_BEYOND);
		add_row(OP_TYPE,      8'hFF,  9'd0,   1'b1, 8'd0,   1, 0, ST_OK);
		add_row(OP_TYPE,      8'h00,  9'h1FF, 1'b1, 8'd0,   2, 0, ST_OK);
		add_row(OP_TYPE,      CR_CHAR, 9'd0,  1'b1, 8'd0,   3, 0, ST_OK);
		add_row(OP_TYPE,      8'h61,  9'd0,   1'b1, 8'd0,   4, 0, ST_OK);
		add_row(OP_PRELOAD,   8'h80,  9'd0,   1'b1, 8'd0,   4, 1, ST_OK);
		add_row(OP_PRELOAD,   CR_CHAR, 9'd0,  1'b1, 8'd0,   4, 2, ST_OK);
		add_row(OP_PRELOAD,   8'h7F,  9'd0,   1'b1, 8'd0,   4, 3, ST_OK);
		add_row(OP_READ,      8'd0,   9'd0,   1'b1, 8'hFF,  4, 3, ST_OK);
		add_row(OP_READ,      8'd0,   9'd6,   1'b1, 8'h80,  4, 3, ST_OK);
		add_row(OP_READ,      8'd0,   9'd7,   1'b1, 8'd0,   4, 3, ST_BEYOND);
		add_row(OP_LEFT,      8'd0,   9'd0,   1'b0, 8'd0,   0, 0, ST_OK);
		add_row(OP_RIGHT,     8'd0,   9'd0,   1'b0, 8'd0,   0, 0, ST_OK);
		add_row(OP_LINE,      8'd0,   9'd0,   1'b0, 8'd0,   0, 0, ST_OK);
		add_row(OP_LINE,      8'hFF,  9'd0,   1'b0, 8'd0,   0, 0, ST_OK);
		add_row(OP_LINE,      8'd1,   9'd0,   1'b0, 8'd0,   0, 0, ST_OK);
		add_row(OP_BACKSPACE, 8'd0,   9'd0,   1'b0, 8'd0,   0, 0, ST_OK);
		add_row(OP_DELETE,    8'd0,   9'd0,   1'b0, 8'd0,   0, 0, ST_OK);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < directed_rows.size(); i++) begin
			drive_item(directed_rows[i].op, directed_rows[i].ch, directed_rows[i].pos,
				directed_rows[i].typed, directed_rows[i].res);
			pace_sender();
		end
		wait_results();

		// fill both sides, open room on the left, then walk down a line with no CR
		repeat (260) send_edit(OP_TYPE, pick_char(20), rnd_pos());
		repeat (260) send_edit(OP_PRELOAD, pick_char(0), rnd_pos());
		repeat (100) send_edit(OP_BACKSPACE, rnd_char(), rnd_pos());
		repeat (3) send_edit(OP_LINE, 8'd1, rnd_pos());

		seg = 0;
		while (accepted < directed_rows.size() + RANDOM_ITEMS) begin
			kind = $urandom_range(9);
			case ($urandom_range(3))
			0:       cr_odds = 0;
			1:       cr_odds = 4;
			2:       cr_odds = 16;
			default: cr_odds = 64;
			endcase
			case (kind)
			0, 1: begin
				len         = $urandom_range(10, 300);
				side_op     = $urandom_range(1) ? OP_TYPE : OP_PRELOAD;
				mixed_sides = ($urandom_range(1) != 0);
				repeat (len) begin
					if (mixed_sides) side_op = $urandom_range(1) ? OP_TYPE : OP_PRELOAD;
					send_edit(side_op, pick_char(cr_odds), rnd_pos());
				end
			end
			2: begin
				len = $urandom_range(10, 300);
				repeat (len)
					send_edit($urandom_range(1) ? OP_BACKSPACE : OP_DELETE, rnd_char(),
						rnd_pos());
			end
			3, 4: begin
				len = $urandom_range(5, 40);
				repeat (len) begin
					if ($urandom_range(3) == 0) begin
						send_edit(OP_READ, rnd_char(), pick_pos());
					end else begin
						if ($urandom_range(1)) line_ch = 8'd0;
						else if ($urandom_range(1)) line_ch = 8'd1;
						else line_ch = CHAR_W'($urandom_range(1, 255));
						send_edit(OP_LINE, line_ch, rnd_pos());
					end
				end
			end
			5: begin
				len  = $urandom_range(10, 100);
				bias = $urandom_range(2);
				repeat (len) begin
					if (bias == 0) side_op = ($urandom_range(3) != 0) ? OP_LEFT : OP_RIGHT;
					else if (bias == 1) side_op = ($urandom_range(3) != 0) ? OP_RIGHT : OP_LEFT;
					else side_op = $urandom_range(1) ? OP_LEFT : OP_RIGHT;
					send_edit(side_op, rnd_char(), rnd_pos());
				end
			end
			6, 7: begin
				len = $urandom_range(10, 60);
				repeat (len) send_edit(OP_READ, rnd_char(), pick_pos());
			end
			8: begin
				len = $urandom_range(10, 80);
				repeat (len) begin
					rnd_op = 3'($urandom_range(7));
					send_edit(rnd_op, pick_char(8), pick_pos());
				end
			end
			default: begin
				len = $urandom_range(5, 40);
				repeat (len) begin
					rnd_op = 3'($urandom_range(7));
					send_edit(rnd_op, rnd_char(), rnd_pos());
				end
			end
			endcase
			if (seg == 5) wait_results();
			seg++;
		end

		wait_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	// back-pressure held long enough to fill the block and stall its input
	initial begin : long_hold
		wait (accepted >= HOLD_AFTER);
		@(posedge clk);
		hold_rx <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_rx <= 1'b0;
	end

	always @(posedge clk) begin : rx_pattern
		bit ready_now;
		if (rx_span == 0) begin
			rx_mode = $urandom_range(3);
			rx_span = $urandom_range(30, 250);
		end else begin
			rx_span--;
		end
		rx_phase++;
		case (rx_mode)
		0:       ready_now = 1'b1;
		1:       ready_now = ($urandom_range(1) != 0);
		2:       ready_now = ($urandom_range(3) == 0);
		default: ready_now = (rx_phase % 3 != 0);
		endcase
		out_ready <= ready_now && !hold_rx;
	end

	always @(posedge clk) begin : result_check
		edit_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (line_results.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("unexpected item: char %0d left %0d right %0d status %0d",
						char_out, left_count, right_count, status);
			end else begin
				want = line_results.pop_front();
				if (want.chr !== char_out || want.lcnt !== left_count ||
						want.rcnt !== right_count || want.st !== status) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("mismatch char/left/right/status: exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
							want.chr, want.lcnt, want.rcnt, want.st,
							char_out, left_count, right_count, status);
				end
			end
		end
	end

	always @(posedge clk) begin : watchdog
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

endmodule

// ----- files.f -----
hdl/gble_pkg.sv
hdl/gap_buffer_line_editor.sv
hdl/gble_checker.sv
tb/sv/gap_buffer_line_editor_tb.sv
